// ===== src/bfs_pkg.sv =====
// Shared types and constants for the boids steering block.
package bfs_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int MAX_BOIDS    = 256;
    localparam int RADIUS_W     = 31;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(300 << FRAC_BITS);
    localparam int POS_W        = 32;
    localparam int VEL_W        = 24;
    localparam int STEER_W      = 16;
    localparam int CNT_W        = 9;
    localparam int SUM_W        = 32;
    localparam int Q_DEPTH      = 16;
    localparam int Q_AW         = 4;
    localparam int PIPE_DEPTH   = 6;

    // One classified word from the front part
    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] vz;
        logic                    hit;
        logic                    last;
    } bfs_entry_t;

    typedef logic [2:0][SUM_W-1:0]   bfs_vec_t;
    typedef logic [2:0][STEER_W-1:0] bfs_dir_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQUARE,
        N_SQRT,
        N_DIVLD,
        N_DIV,
        N_DONE
    } bfs_norm_state_t;

    typedef enum logic [1:0] {
        B_ACC,
        B_PASS1,
        B_PASS2
    } bfs_back_state_t;

endpackage

// ===== src/bfs_front.sv =====
// Front part: radius register, distance pipeline and neighbour classification.
module bfs_front import bfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [RADIUS_W-1:0]      cfg_wr_data,
    input  logic                     push,
    input  logic signed [POS_W-1:0]  own_x,
    input  logic signed [POS_W-1:0]  own_y,
    input  logic signed [POS_W-1:0]  own_z,
    input  logic signed [POS_W-1:0]  other_x,
    input  logic signed [POS_W-1:0]  other_y,
    input  logic signed [POS_W-1:0]  other_z,
    input  logic signed [VEL_W-1:0]  other_vx,
    input  logic signed [VEL_W-1:0]  other_vy,
    input  logic signed [VEL_W-1:0]  other_vz,
    input  logic                     is_own,
    input  logic                     last_other,
    input  logic [Q_AW:0]            q_count,
    output logic                     full,
    output logic                     out_valid,
    output bfs_entry_t               out_entry
);

    logic [RADIUS_W-1:0]        radius_reg;
    logic [2*RADIUS_W-1:0]      rsq_reg;
    logic [PIPE_DEPTH-1:0]      v_reg;
    logic                       accept;
    logic [Q_AW+1:0]            occ;

    // payload carried along the pipe: velocity, candidate and last flags
    bfs_entry_t                 e1_reg, e2_reg, e3_reg, e4_reg, e5_reg, e6_reg;
    logic signed [POS_W:0]      d_reg [3];
    logic [POS_W:0]             m_reg [3];
    logic [33:0]                hh_reg [3];
    logic [32:0]                hl_reg [3];
    logic [31:0]                ll_reg [3];
    logic [64:0]                sq_reg [3];
    logic [65:0]                sum_reg;

    assign accept = push && !full;

    // credit check: words in flight plus queued words never exceed the queue
    assign occ  = (Q_AW+2)'(q_count) + (Q_AW+2)'($countones(v_reg));
    assign full = occ >= (Q_AW+2)'(Q_DEPTH);

    // radius register and valid-bit shift register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            v_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
            v_reg <= {v_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        rsq_reg <= (2*RADIUS_W)'(radius_reg) * (2*RADIUS_W)'(radius_reg);

        // stage 1: offsets
        d_reg[0] <= $signed({other_x[POS_W-1], other_x}) - $signed({own_x[POS_W-1], own_x});
        d_reg[1] <= $signed({other_y[POS_W-1], other_y}) - $signed({own_y[POS_W-1], own_y});
        d_reg[2] <= $signed({other_z[POS_W-1], other_z}) - $signed({own_z[POS_W-1], own_z});
        e1_reg.vx   <= other_vx;
        e1_reg.vy   <= other_vy;
        e1_reg.vz   <= other_vz;
        e1_reg.hit  <= !is_own;
        e1_reg.last <= last_other;

        for (int i = 0; i < 3; i++)
        begin
            // stage 2: magnitudes
            m_reg[i]  <= d_reg[i][POS_W] ? (POS_W+1)'(-d_reg[i]) : (POS_W+1)'(d_reg[i]);
            // stage 3: partial products
            hh_reg[i] <= 34'(m_reg[i][32:16]) * 34'(m_reg[i][32:16]);
            hl_reg[i] <= 33'(m_reg[i][32:16]) * 33'(m_reg[i][15:0]);
            ll_reg[i] <= m_reg[i][15:0] * m_reg[i][15:0];
            // stage 4: squares
            sq_reg[i] <= {hh_reg[i][32:0], 32'b0} + {15'b0, hl_reg[i], 17'b0}
                         + {33'b0, ll_reg[i]};
        end

        // stage 5: squared distance
        sum_reg <= 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);

        // stage 6: classification
        e6_reg <= '{vx:   e5_reg.vx,
                    vy:   e5_reg.vy,
                    vz:   e5_reg.vz,
                    hit:  e5_reg.hit && (sum_reg < {4'b0, rsq_reg}),
                    last: e5_reg.last};

        e2_reg <= e1_reg;
        e3_reg <= e2_reg;
        e4_reg <= e3_reg;
        e5_reg <= e4_reg;
    end

    assign out_valid = v_reg[PIPE_DEPTH-1];
    assign out_entry = e6_reg;

endmodule

// ===== src/bfs_queue.sv =====
// Short queue of classified words between the front and back parts.
module bfs_queue import bfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  bfs_entry_t  wr_data,
    input  logic        rd_en,
    output bfs_entry_t  rd_data,
    output logic        q_empty,
    output logic [Q_AW:0] count
);

    bfs_entry_t      mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (Q_AW+1)'(wr_en) - (Q_AW+1)'(rd_en);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign q_empty = count_reg == '0;
    assign count   = count_reg;

endmodule

// ===== src/bfs_norm.sv =====
// Iterative vector normaliser: shift, sum of squares, square root, division.
module bfs_norm import bfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  bfs_vec_t in_vec,
    output logic     done,
    output bfs_dir_t out_vec
);

    bfs_norm_state_t state_reg, state_next;
    logic [2:0]        neg_reg, neg_next;
    logic [31:0]       mag_reg [3];
    logic [31:0]       mag_next [3];
    logic [1:0]        idx_reg, idx_next;
    logic [61:0]       acc_reg, acc_next;
    logic [61:0]       n_reg, n_next;
    logic [61:0]       res_reg, res_next;
    logic [60:0]       bit_reg, bit_next;
    logic [31:0]       rem_reg, rem_next;
    logic [15:0]       nlo_reg, nlo_next;
    logic [15:0]       q_reg, q_next;
    logic [3:0]        cnt_reg, cnt_next;
    bfs_dir_t          out_reg, out_next;

    logic [31:0] max01, max_mag, mag_sel, len;
    logic [59:0] sq;
    logic [61:0] trial;
    logic [45:0] num;
    logic [32:0] r2;
    logic        qb;
    logic [15:0] qf, qc;

    assign mag_sel = mag_reg[idx_reg];
    assign max01   = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
    assign max_mag = (max01 > mag_reg[2]) ? max01 : mag_reg[2];
    assign len     = res_reg[31:0];

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        nlo_reg <= nlo_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        n_next     = n_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        nlo_next   = nlo_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        sq         = mag_sel[29:0] * mag_sel[29:0];
        trial      = res_reg + 62'(bit_reg);
        num        = {1'b0, mag_sel[29:0], 15'b0} + 46'(len[31:1]);
        r2         = {rem_reg, nlo_reg[15]};
        qb         = r2 >= {1'b0, len};
        qf         = {q_reg[14:0], qb};
        qc         = qf[15] ? 16'd32767 : qf;

        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = in_vec[i][31];
                        mag_next[i] = in_vec[i][31] ? 32'(32'd0 - in_vec[i]) : in_vec[i];
                    end
                    state_next = N_SHIFT;
                end
            end
            // bring the largest magnitude into [2^29, 2^30); an all-zero vector gives zero
            N_SHIFT:
            begin
                if (max_mag == '0)
                begin
                    out_next   = '0;
                    state_next = N_DONE;
                end
                else if (max_mag[31:30] != 2'b00)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (!max_mag[29])
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = N_SQUARE;
                end
            end
            // one square per cycle
            N_SQUARE:
            begin
                if (idx_reg == 2'd2)
                begin
                    n_next     = acc_reg + 62'(sq);
                    res_next   = '0;
                    bit_next   = 61'(1) << 60;
                    state_next = N_SQRT;
                end
                else
                begin
                    acc_next = acc_reg + 62'(sq);
                    idx_next = idx_reg + 1'b1;
                end
            end
            // integer square root, one result bit per cycle
            N_SQRT:
            begin
                if (n_reg >= trial)
                begin
                    n_next   = n_reg - trial;
                    res_next = (res_reg >> 1) + 62'(bit_reg);
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 61'd1)
                begin
                    idx_next   = '0;
                    state_next = N_DIVLD;
                end
            end
            // rounded numerator; high part is already below the length
            N_DIVLD:
            begin
                rem_next   = 32'(num[45:16]);
                nlo_next   = num[15:0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = N_DIV;
            end
            // restoring division, one quotient bit per cycle
            N_DIV:
            begin
                rem_next = qb ? 32'(r2 - {1'b0, len}) : r2[31:0];
                nlo_next = nlo_reg << 1;
                q_next   = qf;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    out_next[idx_reg] = neg_reg[idx_reg] ? 16'(16'd0 - qc) : qc;
                    if (idx_reg == 2'd2)
                    begin
                        state_next = N_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = N_DIVLD;
                    end
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    assign done    = state_reg == N_DONE;
    assign out_vec = out_reg;

endmodule

// ===== src/bfs_back.sv =====
// Back part: neighbour sums, two normalisation passes and the result register.
module bfs_back import bfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  bfs_entry_t         head,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic signed [STEER_W-1:0] steer_x,
    output logic signed [STEER_W-1:0] steer_y,
    output logic signed [STEER_W-1:0] steer_z,
    output logic [CNT_W-1:0]   neighbors_found
);

    bfs_back_state_t state_reg, state_next;
    logic signed [SUM_W-1:0] vs_reg [3];
    logic signed [SUM_W-1:0] vs_next [3];
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        rcnt_reg, rcnt_next;
    bfs_vec_t                nv_reg, nv_next;
    bfs_dir_t                res_reg, res_next;
    logic                    ov_reg, ov_next;
    logic                    start;
    logic                    add;
    logic [CNT_W-1:0]        cnt_add;
    logic signed [SUM_W-1:0] vs_add [3];
    logic                    n_done;
    bfs_dir_t                n_out;

    bfs_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_vec  (nv_reg),
        .done    (n_done),
        .out_vec (n_out)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_ACC;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            vs_reg    <= vs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rcnt_reg <= rcnt_next;
        nv_reg   <= nv_next;
        res_reg  <= res_next;
    end

    // accumulate and sequence the two passes
    always_comb
    begin
        state_next = state_reg;
        vs_next    = vs_reg;
        cnt_next   = cnt_reg;
        rcnt_next  = rcnt_reg;
        nv_next    = nv_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && !pop;
        start      = 1'b0;
        q_pop      = 1'b0;
        add        = head.hit && (cnt_reg < CNT_W'(MAX_BOIDS));
        cnt_add    = cnt_reg + CNT_W'(add);
        vs_add[0]  = vs_reg[0] + (add ? SUM_W'(head.vx) : '0);
        vs_add[1]  = vs_reg[1] + (add ? SUM_W'(head.vy) : '0);
        vs_add[2]  = vs_reg[2] + (add ? SUM_W'(head.vz) : '0);

        unique case (state_reg)
            B_ACC:
            begin
                if (!q_empty && (!head.last || !ov_reg))
                begin
                    q_pop = 1'b1;
                    if (head.last)
                    begin
                        rcnt_next  = cnt_add;
                        nv_next    = {vs_add[2], vs_add[1], vs_add[0]};
                        cnt_next   = '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            vs_next[i] = '0;
                        end
                        state_next = B_PASS1;
                    end
                    else
                    begin
                        cnt_next = cnt_add;
                        vs_next  = vs_add;
                    end
                end
            end
            // cohesion and separation cancel: the sum is the unit velocity
            B_PASS1:
            begin
                start = !n_done;
                if (n_done)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        nv_next[i] = SUM_W'($signed(n_out[i]));
                    end
                    state_next = B_PASS2;
                end
            end
            B_PASS2:
            begin
                start = !n_done;
                if (n_done)
                begin
                    res_next   = n_out;
                    ov_next    = 1'b1;
                    state_next = B_ACC;
                end
            end
            default:
            begin
                state_next = B_ACC;
            end
        endcase
    end

    assign empty           = !ov_reg;
    assign steer_x         = res_reg[0];
    assign steer_y         = res_reg[1];
    assign steer_z         = res_reg[2];
    assign neighbors_found = rcnt_reg;

endmodule

// ===== src/boids_flock_steering.sv =====
// Boids steering block: top level joining front, queue and back parts.
//
//  channel   direction  handshake          payload
//  item      in         push / full        own_*, other_*, other_v*, is_own, last_other
//  result    out        empty / pop        steer_x/y/z, neighbors_found
//  config    in         cfg_wr_en          cfg_wr_data (neighbour radius)
//
// The front pipeline takes one word per cycle while not full and is six stages
// deep; the back part drains one word per cycle into the sums outside the
// passes. On the last word of a set the back runs two normalisation passes in
// a shared iterative unit (shift search, three squares, 31-step square root,
// three 16-step divisions) while the front keeps filling the 16-entry queue.
// Reset clears control state and loads the radius with 300.0.
module boids_flock_steering import bfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [RADIUS_W-1:0]      cfg_wr_data,
    input  logic                     push,
    output logic                     full,
    input  logic signed [POS_W-1:0]  own_x,
    input  logic signed [POS_W-1:0]  own_y,
    input  logic signed [POS_W-1:0]  own_z,
    input  logic signed [POS_W-1:0]  other_x,
    input  logic signed [POS_W-1:0]  other_y,
    input  logic signed [POS_W-1:0]  other_z,
    input  logic signed [VEL_W-1:0]  other_vx,
    input  logic signed [VEL_W-1:0]  other_vy,
    input  logic signed [VEL_W-1:0]  other_vz,
    input  logic                     is_own,
    input  logic                     last_other,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [STEER_W-1:0] steer_x,
    output logic signed [STEER_W-1:0] steer_y,
    output logic signed [STEER_W-1:0] steer_z,
    output logic [CNT_W-1:0]         neighbors_found
);

    logic        f_valid;
    bfs_entry_t  f_entry;
    bfs_entry_t  head;
    logic        q_empty;
    logic        q_pop;
    logic [Q_AW:0] q_count;

    bfs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .own_x       (own_x),
        .own_y       (own_y),
        .own_z       (own_z),
        .other_x     (other_x),
        .other_y     (other_y),
        .other_z     (other_z),
        .other_vx    (other_vx),
        .other_vy    (other_vy),
        .other_vz    (other_vz),
        .is_own      (is_own),
        .last_other  (last_other),
        .q_count     (q_count),
        .full        (full),
        .out_valid   (f_valid),
        .out_entry   (f_entry)
    );

    bfs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid),
        .wr_data (f_entry),
        .rd_en   (q_pop),
        .rd_data (head),
        .q_empty (q_empty),
        .count   (q_count)
    );

    bfs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .head            (head),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .steer_x         (steer_x),
        .steer_y         (steer_y),
        .steer_z         (steer_z),
        .neighbors_found (neighbors_found)
    );

endmodule

// ===== sim/bfs_checker.sv =====
// Steering checker: watches the item, result and radius channels and compares.
module bfs_checker import bfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [RADIUS_W-1:0]       cfg_wr_data,
    input  logic                      push,
    input  logic                      full,
    input  logic signed [POS_W-1:0]   own_x,
    input  logic signed [POS_W-1:0]   own_y,
    input  logic signed [POS_W-1:0]   own_z,
    input  logic signed [POS_W-1:0]   other_x,
    input  logic signed [POS_W-1:0]   other_y,
    input  logic signed [POS_W-1:0]   other_z,
    input  logic signed [VEL_W-1:0]   other_vx,
    input  logic signed [VEL_W-1:0]   other_vy,
    input  logic signed [VEL_W-1:0]   other_vz,
    input  logic                      is_own,
    input  logic                      last_other,
    input  logic                      empty,
    input  logic                      pop,
    input  logic signed [STEER_W-1:0] steer_x,
    input  logic signed [STEER_W-1:0] steer_y,
    input  logic signed [STEER_W-1:0] steer_z,
    input  logic [CNT_W-1:0]          neighbors_found,
    output int                        errors,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint trio_t [3];

    typedef struct {
        logic signed [STEER_W-1:0] sx;
        logic signed [STEER_W-1:0] sy;
        logic signed [STEER_W-1:0] sz;
        logic [CNT_W-1:0]          cnt;
    } steer_word_t;

    steer_word_t    steer_due[$];
    logic [RADIUS_W-1:0] radius;
    trio_t          vel_acc;
    trio_t          off_acc;
    int             nb_count;

    assign pending = steer_due.size();

    // integer square root, bit by bit
    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (n >= res + bit_v)
            begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
                res >>= 1;
            bit_v >>= 2;
        end
        return res;
    endfunction

    // unit direction in Q1.15; zero stays zero
    function automatic trio_t unit_dir(trio_t c);
        longint unsigned mag [3];
        longint unsigned m, s, len, q;
        trio_t r;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = c[i] < 0 ? -c[i] : c[i];
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
        begin
            r = '{0, 0, 0};
            return r;
        end
        while (m >= (64'd1 << 30))
        begin
            m >>= 1;
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            m <<= 1;
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
        end
        for (int i = 0; i < 3; i++)
            s += mag[i] * mag[i];
        len = root64(s);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] * 32768 + len / 2) / len;
            if (q > 32767)
                q = 32767;
            r[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        return r;
    endfunction

    // accumulate one word, and on the last word of a set queue the direction
    task automatic take_word();
        trio_t off, vel, a, co, se, ng, d, r;
        logic [67:0] dsq;
        logic [67:0] rsq;
        longint unsigned mg;
        steer_word_t w;
        off[0] = longint'(other_x) - longint'(own_x);
        off[1] = longint'(other_y) - longint'(own_y);
        off[2] = longint'(other_z) - longint'(own_z);
        vel[0] = longint'(other_vx);
        vel[1] = longint'(other_vy);
        vel[2] = longint'(other_vz);
        dsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            mg = off[i] < 0 ? -off[i] : off[i];
            dsq += 68'(mg) * 68'(mg);
        end
        rsq = 68'(radius) * 68'(radius);
        if (!is_own && dsq < rsq && nb_count < MAX_BOIDS)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vel_acc[i] += vel[i];
                off_acc[i] += off[i];
            end
            nb_count++;
        end
        if (last_other)
        begin
            a  = unit_dir(vel_acc);
            co = unit_dir(off_acc);
            for (int i = 0; i < 3; i++)
                ng[i] = -off_acc[i];
            se = unit_dir(ng);
            for (int i = 0; i < 3; i++)
                d[i] = a[i] + co[i] + se[i];
            r = unit_dir(d);
            w.sx  = STEER_W'(r[0]);
            w.sy  = STEER_W'(r[1]);
            w.sz  = STEER_W'(r[2]);
            w.cnt = CNT_W'(nb_count);
            steer_due.push_back(w);
            vel_acc = '{0, 0, 0};
            off_acc = '{0, 0, 0};
            nb_count = 0;
        end
    endtask

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        steer_word_t w;
        if (!rst_n)
        begin
            radius   <= RADIUS_RESET;
            vel_acc  = '{0, 0, 0};
            off_acc  = '{0, 0, 0};
            nb_count = 0;
            errors   <= 0;
            steer_due.delete();
        end
        else
        begin
            if (push && !full)
                take_word();
            if (cfg_wr_en)
                radius <= cfg_wr_data;
            if (pop && !empty)
            begin
                if (steer_due.size() == 0)
                begin
                    $display("%t: unexpected word x=%0d y=%0d z=%0d n=%0d", $realtime,
                             steer_x, steer_y, steer_z, neighbors_found);
                    errors <= errors + 1;
                end
                else
                begin
                    w = steer_due.pop_front();
                    if (w.sx !== steer_x || w.sy !== steer_y || w.sz !== steer_z
                        || w.cnt !== neighbors_found)
                    begin
                        $display("%t: expected x=%0d y=%0d z=%0d n=%0d, got %0d %0d %0d %0d",
                                 $realtime, w.sx, w.sy, w.sz, w.cnt,
                                 steer_x, steer_y, steer_z, neighbors_found);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives steering words and radius settings, prints the verdict.
module tb import bfs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [RADIUS_W-1:0]       cfg_wr_data = '0;
    logic                      push = 1'b0;
    logic                      full;
    logic signed [POS_W-1:0]   own_x = '0, own_y = '0, own_z = '0;
    logic signed [POS_W-1:0]   other_x = '0, other_y = '0, other_z = '0;
    logic signed [VEL_W-1:0]   other_vx = '0, other_vy = '0, other_vz = '0;
    logic                      is_own = 1'b0;
    logic                      last_other = 1'b0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic signed [STEER_W-1:0] steer_x, steer_y, steer_z;
    logic [CNT_W-1:0]          neighbors_found;
    int                        errors;
    int                        pending;

    int                        idle_pct = 0;
    int                        stall_pct = 0;
    longint                    cur_radius = 76800;
    int                        words_sent;

    always #2 clk = ~clk;

    boids_flock_steering u_dut (
        .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .push, .full,
        .own_x, .own_y, .own_z, .other_x, .other_y, .other_z,
        .other_vx, .other_vy, .other_vz, .is_own, .last_other,
        .empty, .pop, .steer_x, .steer_y, .steer_z, .neighbors_found
    );

    bfs_checker u_chk (
        .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .push, .full,
        .own_x, .own_y, .own_z, .other_x, .other_y, .other_z,
        .other_vx, .other_vy, .other_vz, .is_own, .last_other,
        .empty, .pop, .steer_x, .steer_y, .steer_z, .neighbors_found,
        .errors, .pending
    );

    // result side stalls at random
    always @(negedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    // one word through the push/full handshake; called at a falling edge
    task automatic send_word(longint ox, longint oy, longint oz, longint px, longint py,
                             longint pz, longint vx, longint vy, longint vz, bit self, bit fin);
        if ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            repeat (1 + $urandom_range(3)) @(negedge clk);
        end
        own_x <= POS_W'(ox);  own_y <= POS_W'(oy);  own_z <= POS_W'(oz);
        other_x <= POS_W'(px);  other_y <= POS_W'(py);  other_z <= POS_W'(pz);
        other_vx <= VEL_W'(vx);  other_vy <= VEL_W'(vy);  other_vz <= VEL_W'(vz);
        is_own <= self;
        last_other <= fin;
        push <= 1'b1;
        // full as seen at the rising edge decides the acceptance
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    function automatic longint rnd32();
        return longint'(int'($urandom));
    endfunction

    function automatic longint rnd24();
        return longint'($signed(VEL_W'($urandom)));
    endfunction

    // a word near its own boid, inside the current radius unless that radius is zero
    task automatic near_word(longint ox, longint oy, longint oz, bit self, bit fin);
        longint lim;
        longint d [3];
        lim = cur_radius >> ($urandom_range(1) ? 1 : 3);
        for (int i = 0; i < 3; i++)
            d[i] = longint'($urandom_range(32'(2 * lim))) - lim;
        send_word(ox, oy, oz, ox + d[0], oy + d[1], oz + d[2],
                  rnd24(), rnd24(), rnd24(), self, fin);
    endtask

    // one set: mostly neighbours, some self and far words
    task automatic random_set(int len);
        longint ox, oy, oz;
        bit fin;
        int k;
        ox = rnd32() >>> 2;
        oy = rnd32() >>> 2;
        oz = rnd32() >>> 2;
        for (int i = 0; i < len; i++)
        begin
            fin = (i == len - 1);
            k = $urandom_range(99);
            if (k < 60)
                near_word(ox, oy, oz, 1'b0, fin);
            else if (k < 72)
                near_word(ox, oy, oz, 1'b1, fin);
            else
                send_word(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
                          rnd24(), rnd24(), rnd24(), $urandom_range(1), fin);
        end
    endtask

    task automatic write_radius(longint r);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= RADIUS_W'(r);
        cur_radius = r;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for every direction to drain and the back part to go quiet
    task automatic drain();
        push <= 1'b0;
        wait (pending == 0);
        repeat (300) @(negedge clk);
    endtask

    initial
    begin
        longint radii [5];
        radii = '{76800, 0, 64'h7FFF_FFFF, 1000, 0};
        words_sent = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, radius boundary, self and zero offset
        send_word(64'h7FFF_FFFF, -64'h8000_0000, 0, -64'h8000_0000, 64'h7FFF_FFFF, -1,
                  8388607, -8388608, 0, 1'b0, 1'b1);
        send_word(0, 0, 0, 100, -200, 300, 8388607, 8388607, 8388607, 1'b0, 1'b0);
        send_word(0, 0, 0, -100, 200, -300, -8388608, -8388608, -8388608, 1'b0, 1'b0);
        send_word(0, 0, 0, 0, 0, 0, 5, 5, 5, 1'b1, 1'b1);
        send_word(1000, 1000, 1000, 1000 + 76800, 1000, 1000, 7, 8, 9, 1'b0, 1'b1);
        send_word(1000, 1000, 1000, 1000 + 76799, 1000, 1000, 7, 8, 9, 1'b0, 1'b1);
        send_word(-5, -5, -5, -5, -5, -5, 0, 0, 0, 1'b0, 1'b1);
        send_word(3, 3, 3, 10, 3, 3, 0, 0, 0, 1'b0, 1'b0);
        send_word(3, 3, 3, -10, 3, 3, 0, 0, 0, 1'b0, 1'b1);
        send_word(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b1, 1'b1);
        send_word(0, 0, 0, 76799, 0, 0, 0, 0, 0, 1'b1, 1'b0);
        send_word(0, 0, 0, 0, -76799, 0, 1, 0, 0, 1'b0, 1'b1);
        drain();

        // phases: radius settings crossed with idle and stall modes
        for (int p = 0; p < 5; p++)
        begin
            int goal;
            if (p > 0)
                write_radius(p == 4 ? longint'($urandom_range(32'h7FFF_FFFF)) : radii[p]);
            idle_pct  = (p % 4 == 1) ? 68 : (p % 4 == 3) ? 22 : 0;
            stall_pct = (p % 4 == 2) ? 68 : (p % 4 == 3) ? 22 : 0;
            goal = words_sent + 120;
            // more neighbours than the block counts
            if (p == 2)
            begin
                longint ox, oy, oz;
                ox = rnd32() >>> 2;
                oy = rnd32() >>> 2;
                oz = rnd32() >>> 2;
                for (int i = 0; i < 262; i++)
                    near_word(ox, oy, oz, 1'b0, i == 261);
            end
            while (words_sent < goal)
                random_set(1 + $urandom_range(($urandom_range(3) == 0) ? 40 : 10));
            drain();
        end

        if (errors == 0)
            $display("boids_flock_steering test passed");
        else
            $display("boids_flock_steering test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #3ms;
        $display("boids_flock_steering test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/bfs_pkg.sv
src/bfs_front.sv
src/bfs_queue.sv
src/bfs_norm.sv
src/bfs_back.sv
src/boids_flock_steering.sv
sim/bfs_checker.sv
sim/tb.sv
